@@ sv/command_line_tokenizer_defines.svh @@
// -----------------------------------------------------------------------------
// Command line tokenizer: assertion macros
// Shared property wrappers for the tokenizer's concurrent checks.
// -----------------------------------------------------------------------------
`ifndef COMMAND_LINE_TOKENIZER_DEFINES_SVH
`define COMMAND_LINE_TOKENIZER_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define CLT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tokenizer check failed (same cycle)");

// Check that cons holds in the cycle after ante
`define CLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tokenizer check failed (next cycle)");

`endif

@@ sv/cltok_pkg.sv @@
// -----------------------------------------------------------------------------
// Command line tokenizer package
// Parse modes, result record, character codes and small helper functions.
// -----------------------------------------------------------------------------
package cltok_pkg;

	// Width of the saturating line and token counters
	localparam int COUNT_BITS = 16;
	// Width of the counter fields on the result port
	localparam int OUT_BITS = 16;

	// Result queue geometry
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_BITS = $clog2(FIFO_DEPTH);
	localparam int FILL_BITS = $clog2(FIFO_DEPTH + 1);

	// Character codes
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LC_N = 8'h6E;
	localparam logic [7:0] CH_LC_R = 8'h72;
	localparam logic [7:0] CH_LC_T = 8'h74;
	localparam logic [7:0] SEP_LOW_MAX = 8'd32;
	localparam logic [7:0] SEP_HIGH_MIN = 8'd127;

	// Result kinds
	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END = 1'b1;

	typedef enum logic [2:0] {
		MODE_SKIP = 3'd0,
		MODE_QUOTED = 3'd1,
		MODE_QESC = 3'd2,
		MODE_BARE = 3'd3,
		MODE_BESC = 3'd4,
		MODE_DONE = 3'd5
	} mode_t;

	typedef logic [COUNT_BITS-1:0] count_t;

	typedef struct packed {
		logic kind;
		logic [7:0] char_val;
		logic last_tok;
		logic [OUT_BITS-1:0] tok_idx;
		logic [OUT_BITS-1:0] line_num;
		logic last_run;
	} result_t;

	function automatic logic is_sep(input logic [7:0] b);
		return (b <= SEP_LOW_MAX) || (b >= SEP_HIGH_MIN);
	endfunction

	function automatic logic [7:0] translate(input logic [7:0] b);
		logic [7:0] r;
		case (b)
			CH_LC_N: r = CH_LF;
			CH_LC_R: r = CH_CR;
			CH_LC_T: r = CH_TAB;
			default: r = b;
		endcase
		return r;
	endfunction

	function automatic count_t sat_inc(input count_t v);
		return (v == {COUNT_BITS{1'b1}}) ? v : count_t'(v + 1'b1);
	endfunction

	// Low bits of a counter for the result port, zero extended if narrower
	function automatic logic [OUT_BITS-1:0] to_out(input count_t v);
		logic [COUNT_BITS+OUT_BITS-1:0] ext;
		ext = {{OUT_BITS{1'b0}}, v};
		return ext[OUT_BITS-1:0];
	endfunction

endpackage

@@ sv/command_line_tokenizer.sv @@
// -----------------------------------------------------------------------------
// Command line tokenizer
// Splits a byte stream into quoted or bare tokens, translates escapes and
// streams token characters out with the final character of each token flagged.
// -----------------------------------------------------------------------------
//
//  Channel | Handshake          | Payload
//  --------+--------------------+-----------------------------------------------
//  input   | in_valid/in_ready  | byte_value, first_of_buffer
//  output  | out_valid/out_ready| item_kind, char_value, last_of_token,
//          |                    | token_index, line_number, last_of_run
//
// A byte is registered at the input, then parsed combinationally; its zero,
// one or two results go into a four-entry result queue. One byte per cycle is
// taken while the queue holds at most two results, so the rate is one byte per
// cycle whenever results drain as fast as they are made; the two results of a
// byte are read out of the queue one at a time. Reset clears the parse state
// and the queue at once; no clearing pass. Output stalls back up through the
// queue into the input register.
//
module command_line_tokenizer
	import cltok_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [7:0] byte_value,
	input  logic first_of_buffer,
	output logic out_valid,
	input  logic out_ready,
	output logic item_kind,
	output logic [7:0] char_value,
	output logic last_of_token,
	output logic [OUT_BITS-1:0] token_index,
	output logic [OUT_BITS-1:0] line_number,
	output logic last_of_run
);

`include "command_line_tokenizer_defines.svh"

	// Input stage
	logic valid_s1;
	logic [7:0] byte_s1;
	logic first_s1;
	logic adv_s1;

	// Parse state
	mode_t mode_q, mode_n;
	logic [7:0] held_char_q, held_char_n;
	logic held_valid_q, held_valid_n;
	count_t line_count_q, line_count_n;
	count_t token_count_q, token_count_n;

	// Results of the current byte
	result_t res0, res1;
	logic [1:0] num_res;

	// Result queue
	result_t fifo_q [FIFO_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [FILL_BITS-1:0] fill_q;
	logic pop;

	// Advance the input stage when the queue has room for two results
	assign adv_s1 = valid_s1 && (fill_q <= FILL_BITS'(FIFO_DEPTH - 2));
	assign in_ready = !valid_s1 || adv_s1;

	// Hold the accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= byte_value;
			first_s1 <= first_of_buffer;
		end
	end

	// Parse one byte: next state and up to two results
	always_comb begin
		mode_t m;
		logic [7:0] hc;
		logic hv;
		count_t ln;
		count_t tk;
		logic do_push, do_fin, do_end, line_inc, char_emit;
		logic [7:0] push_c;

		m = first_s1 ? MODE_SKIP : mode_q;
		hc = first_s1 ? CH_NUL : held_char_q;
		hv = first_s1 ? 1'b0 : held_valid_q;
		ln = first_s1 ? '0 : line_count_q;
		tk = first_s1 ? '0 : token_count_q;

		do_push = 1'b0;
		do_fin = 1'b0;
		do_end = 1'b0;
		line_inc = 1'b0;
		push_c = byte_s1;
		mode_n = m;

		unique case (m)
			MODE_SKIP: begin
				if (byte_s1 == CH_NUL) begin
					do_end = 1'b1;
				end else if (is_sep(byte_s1)) begin
					line_inc = (byte_s1 == CH_LF);
				end else if (byte_s1 == CH_QUOTE) begin
					mode_n = MODE_QUOTED;
				end else if (byte_s1 == CH_BSLASH) begin
					mode_n = MODE_BESC;
				end else begin
					do_push = 1'b1;
					mode_n = MODE_BARE;
				end
			end
			MODE_QUOTED: begin
				if (byte_s1 == CH_NUL) begin
					do_fin = 1'b1;
					do_end = 1'b1;
				end else if (byte_s1 == CH_QUOTE) begin
					if (hv) begin
						do_fin = 1'b1;
						mode_n = MODE_SKIP;
					end else begin
						do_end = 1'b1;
					end
				end else if (byte_s1 == CH_BSLASH) begin
					mode_n = MODE_QESC;
				end else begin
					do_push = 1'b1;
				end
			end
			MODE_QESC: begin
				if (byte_s1 == CH_NUL) begin
					do_fin = 1'b1;
					do_end = 1'b1;
				end else begin
					do_push = 1'b1;
					push_c = translate(byte_s1);
					mode_n = MODE_QUOTED;
				end
			end
			MODE_BARE: begin
				if (byte_s1 == CH_NUL) begin
					do_fin = 1'b1;
					do_end = 1'b1;
				end else if (is_sep(byte_s1)) begin
					do_fin = 1'b1;
					line_inc = (byte_s1 == CH_LF);
					mode_n = MODE_SKIP;
				end else if (byte_s1 == CH_BSLASH) begin
					mode_n = MODE_BESC;
				end else begin
					do_push = 1'b1;
				end
			end
			MODE_BESC: begin
				if (byte_s1 == CH_NUL) begin
					do_fin = 1'b1;
					do_end = 1'b1;
				end else begin
					do_push = 1'b1;
					push_c = translate(byte_s1);
					mode_n = MODE_BARE;
				end
			end
			MODE_DONE: begin
				mode_n = MODE_DONE;
			end
			default: begin
				mode_n = MODE_DONE;
			end
		endcase

		// Held character goes out on a push or a finish
		char_emit = (do_push || do_fin) && hv;

		held_char_n = hc;
		held_valid_n = hv;
		token_count_n = tk;
		if (do_push) begin
			held_char_n = push_c;
			held_valid_n = 1'b1;
		end else if (do_fin && hv) begin
			held_char_n = CH_NUL;
			held_valid_n = 1'b0;
			token_count_n = sat_inc(tk);
		end
		line_count_n = line_inc ? sat_inc(ln) : ln;
		if (do_end) begin
			mode_n = MODE_DONE;
		end

		// Character result, taken before the token count advances
		res0.kind = KIND_CHAR;
		res0.char_val = hc;
		res0.last_tok = do_fin;
		res0.tok_idx = to_out(tk);
		res0.line_num = to_out(ln);
		res0.last_run = !do_end;

		// End-of-parse result
		res1.kind = KIND_END;
		res1.char_val = CH_NUL;
		res1.last_tok = 1'b0;
		res1.tok_idx = to_out(token_count_n);
		res1.line_num = to_out(ln);
		res1.last_run = 1'b1;

		if (!char_emit) begin
			res0 = res1;
		end
		num_res = {1'b0, char_emit} + {1'b0, do_end};
	end

	// Update parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SKIP;
			held_char_q <= CH_NUL;
			held_valid_q <= 1'b0;
			line_count_q <= '0;
			token_count_q <= '0;
		end else if (adv_s1) begin
			mode_q <= mode_n;
			held_char_q <= held_char_n;
			held_valid_q <= held_valid_n;
			line_count_q <= line_count_n;
			token_count_q <= token_count_n;
		end
	end

	// Result queue: two writes, one read per cycle
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (adv_s1) begin
				wr_ptr_q <= PTR_BITS'(wr_ptr_q + num_res);
			end
			if (pop) begin
				rd_ptr_q <= PTR_BITS'(rd_ptr_q + 1'b1);
			end
			fill_q <= FILL_BITS'(fill_q + (adv_s1 ? FILL_BITS'(num_res) : '0)
				- (pop ? FILL_BITS'(1) : '0));
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && (num_res != 2'd0)) begin
			fifo_q[wr_ptr_q] <= res0;
		end
		if (adv_s1 && (num_res == 2'd2)) begin
			fifo_q[PTR_BITS'(wr_ptr_q + 1'b1)] <= res1;
		end
	end

	// Drive the result port from the queue head
	assign out_valid = (fill_q != '0);
	assign item_kind = fifo_q[rd_ptr_q].kind;
	assign char_value = fifo_q[rd_ptr_q].char_val;
	assign last_of_token = fifo_q[rd_ptr_q].last_tok;
	assign token_index = fifo_q[rd_ptr_q].tok_idx;
	assign line_number = fifo_q[rd_ptr_q].line_num;
	assign last_of_run = fifo_q[rd_ptr_q].last_run;

	// Checks
	`CLT_ASSERT_SAME(a_fill_bound, clk, arst_n, 1'b1, fill_q <= FILL_BITS'(FIFO_DEPTH))
	`CLT_ASSERT_SAME(a_held_in_token, clk, arst_n, held_valid_q,
		mode_q == MODE_QUOTED || mode_q == MODE_QESC ||
		mode_q == MODE_BARE || mode_q == MODE_BESC)
	`CLT_ASSERT_NEXT(a_end_is_done, clk, arst_n,
		adv_s1 && (num_res == 2'd2 || (num_res == 2'd1 && res0.kind == KIND_END)),
		mode_q == MODE_DONE)
	`CLT_ASSERT_NEXT(a_tok_monotonic, clk, arst_n, adv_s1 && !first_s1,
		token_count_q >= $past(token_count_q))

endmodule
